// ===== src/fddt_pkg.sv =====
// ----------------------------------------------------------------------------
// fddt_pkg
// Shared types and constants of the frame downscaler with dirty tracking.
// ----------------------------------------------------------------------------
`default_nettype none

package fddt_pkg;

    typedef logic [2:0] t_mode;

    // scan and sampling modes
    localparam t_mode MODE_NATIVE         = 3'd2;
    localparam t_mode MODE_SINGLE         = 3'd3;
    localparam t_mode MODE_INTERLACE      = 3'd4;
    localparam t_mode MODE_SINGLE_ALT     = 3'd5;
    localparam t_mode MODE_CHECKER        = 3'd6;
    localparam t_mode MODE_CHECKER_SINGLE = 3'd7;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOT_LIMIT = 1'b1;

    localparam t_mode       MODE_RESET      = 3'd1;
    localparam logic [15:0] DOT_LIMIT_RESET = 16'd1024;
    localparam logic [15:0] BOX_MIN_EMPTY   = 16'hFFFF;
    localparam logic [16:0] COUNT_MAX       = 17'h1FFFF;

    localparam int NUM_LANES = 4;

    // one sample unpacked: red and blue doubled, green as is
    typedef struct packed {
        logic [5:0] r;
        logic [5:0] g;
        logic [5:0] b;
    } t_lane_rgb;

    typedef struct packed {
        logic [15:0] pixel;
        logic        visited;
        logic        changed;
        logic [7:0]  out_row;
        logic [8:0]  out_col;
        logic        frame_done;
        logic [15:0] top_row;
        logic [7:0]  bottom_row;
        logic [15:0] left_col;
        logic [8:0]  right_col;
        logic [16:0] change_count;
        logic        use_dot_writes;
    } t_result;

endpackage

`default_nettype wire

// ===== src/fddt_if.sv =====
// ----------------------------------------------------------------------------
// fddt_in_if / fddt_out_if
// Valid/ready channels for positions in and downscaled results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface fddt_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  row;
    logic [8:0]  col;
    logic [15:0] sample_top_left;
    logic [15:0] sample_top_right;
    logic [15:0] sample_bottom_left;
    logic [15:0] sample_bottom_right;
    logic        last_of_frame;

    modport source (
        output valid, row, col, sample_top_left, sample_top_right,
               sample_bottom_left, sample_bottom_right, last_of_frame,
        input  ready
    );
    modport sink (
        input  valid, row, col, sample_top_left, sample_top_right,
               sample_bottom_left, sample_bottom_right, last_of_frame,
        output ready
    );
endinterface

interface fddt_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel;
    logic        visited;
    logic        changed;
    logic [7:0]  out_row;
    logic [8:0]  out_col;
    logic        frame_done;
    logic [15:0] top_row;
    logic [7:0]  bottom_row;
    logic [15:0] left_col;
    logic [8:0]  right_col;
    logic [16:0] change_count;
    logic        use_dot_writes;

    modport source (
        output valid, pixel, visited, changed, out_row, out_col, frame_done,
               top_row, bottom_row, left_col, right_col, change_count,
               use_dot_writes,
        input  ready
    );
    modport sink (
        input  valid, pixel, visited, changed, out_row, out_col, frame_done,
               top_row, bottom_row, left_col, right_col, change_count,
               use_dot_writes,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/fddt_lane.sv =====
// ----------------------------------------------------------------------------
// fddt_lane
// Unpacks one RGB565 sample into channel terms for the box sum.
// ----------------------------------------------------------------------------
`default_nettype none

module fddt_lane (
    input  wire logic [15:0]        i_sample,
    output fddt_pkg::t_lane_rgb     o_rgb
);

    always_comb begin
        o_rgb.r = {i_sample[15:11], 1'b0};
        o_rgb.g = i_sample[10:5];
        o_rgb.b = {i_sample[4:0], 1'b0};
    end

endmodule

`default_nettype wire

// ===== src/fddt_merge.sv =====
// ----------------------------------------------------------------------------
// fddt_merge
// Combines the lane terms into one RGB565 pixel according to the mode; native
// mode passes the top left sample through as is.
`default_nettype none

module fddt_merge (
    input  wire fddt_pkg::t_mode                                 i_mode,
    input  wire logic [15:0]                                     i_native,
    input  fddt_pkg::t_lane_rgb [fddt_pkg::NUM_LANES-1:0]        i_lanes,
    output logic [15:0]                                          o_pixel
);

    logic [7:0] sum_r;
    logic [7:0] sum_g;
    logic [7:0] sum_b;

    always_comb begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int k = 0; k < fddt_pkg::NUM_LANES; k++) begin
            sum_r = sum_r + 8'(i_lanes[k].r);
            sum_g = sum_g + 8'(i_lanes[k].g);
            sum_b = sum_b + 8'(i_lanes[k].b);
        end

        case (i_mode)
            fddt_pkg::MODE_NATIVE: begin
                o_pixel = i_native;
            end
            fddt_pkg::MODE_SINGLE, fddt_pkg::MODE_SINGLE_ALT,
            fddt_pkg::MODE_CHECKER_SINGLE: begin
                // top left sample weighted by four
                o_pixel = {i_lanes[0].r[5:1], i_lanes[0].g, i_lanes[0].b[5:1]};
            end
            default: begin
                o_pixel = {sum_r[7:3], sum_g[7:2], sum_b[7:3]};
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/frame_downscale_dirty_tracker.sv =====
// ----------------------------------------------------------------------------
// frame_downscale_dirty_tracker
// 2x2 box downscaler for RGB565 with a stored frame and dirty rectangle.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake         | payload
//  i_in      | in  | valid/ready       | row, col, four samples, last_of_frame
//  o_out     | out | valid/ready       | pixel, flags, position, frame report
//  i_cfg_*   | in  | write enable only | register index, 16-bit data
//
//  one transaction per clock sustained while o_out.ready is high; an item passes
//  the frame store read, then compare/write and the result register
//  after reset all FRAME_W*FRAME_H entries of the frame store are zeroed, one
//  entry a cycle; i_in.ready stays low meanwhile
//  a stalled output holds the result and the compare stage; outside the clear
//  pass, input stalls only when both are full
// ----------------------------------------------------------------------------
`default_nettype none

module frame_downscale_dirty_tracker #(
    parameter int FRAME_W = 320,
    parameter int FRAME_H = 240
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [fddt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [15:0]                     i_cfg_data,
    fddt_in_if.sink                              i_in,
    fddt_out_if.source                           o_out
);

    localparam int DEPTH  = FRAME_W * FRAME_H;
    localparam int ADDR_W = $clog2(DEPTH);

    // configuration
    fddt_pkg::t_mode r_mode;
    logic [15:0]     r_dot_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= fddt_pkg::MODE_RESET;
            r_dot_limit <= fddt_pkg::DOT_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fddt_pkg::CFG_MODE:      r_mode      <= i_cfg_data[2:0];
                fddt_pkg::CFG_DOT_LIMIT: r_dot_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // frame store clearing pass
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // handshake
    logic r_s1_valid;
    logic r_out_valid;
    logic s1_adv;
    logic s1_fire;
    logic in_accept;

    assign s1_adv    = !r_out_valid || o_out.ready;
    assign s1_fire   = r_s1_valid && s1_adv;
    assign i_in.ready = !r_clr_busy && (!r_s1_valid || s1_adv);
    assign in_accept = i_in.valid && i_in.ready;

    // input stage: address and frame store read
    logic              in_frame;
    logic [ADDR_W-1:0] in_addr;

    always_comb begin
        in_frame = (11'(i_in.row) < 11'(FRAME_H)) && (11'(i_in.col) < 11'(FRAME_W));
        in_addr  = in_frame ?
                   ADDR_W'(ADDR_W'(i_in.row) * ADDR_W'(FRAME_W) + ADDR_W'(i_in.col)) :
                   '0;
    end

    logic [7:0]        r_s1_row;
    logic [8:0]        r_s1_col;
    logic              r_s1_last;
    logic              r_s1_in_frame;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [15:0]       r_s1_samp [fddt_pkg::NUM_LANES];
    logic [15:0]       r_rd_data;
    logic              r_fwd_hit;
    logic [15:0]       r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    // compare/write stage signals
    logic [15:0] s1_pixel_calc;
    logic [15:0] s1_pixel;
    logic        s1_visited;
    logic        s1_changed;
    logic [15:0] s1_old;
    logic        wr_en;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_row      <= i_in.row;
            r_s1_col      <= i_in.col;
            r_s1_last     <= i_in.last_of_frame;
            r_s1_in_frame <= in_frame;
            r_s1_addr     <= in_addr;
            r_s1_samp[0]  <= i_in.sample_top_left;
            r_s1_samp[1]  <= i_in.sample_top_right;
            r_s1_samp[2]  <= i_in.sample_bottom_left;
            r_s1_samp[3]  <= i_in.sample_bottom_right;
            // the item leaving now writes at this same edge
            r_fwd_hit     <= wr_en && (r_s1_addr == in_addr);
            r_fwd_data    <= s1_pixel;
        end
    end

    // frame store
    logic [15:0] r_frame_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_frame_mem[r_clr_addr] <= '0;
        end else if (wr_en) begin
            r_frame_mem[r_s1_addr] <= s1_pixel;
        end
        if (in_accept) begin
            r_rd_data <= r_frame_mem[in_addr];
        end
    end

    // lanes and merge
    fddt_pkg::t_lane_rgb [fddt_pkg::NUM_LANES-1:0] lane_rgb;

    for (genvar k = 0; k < fddt_pkg::NUM_LANES; k++) begin : g_lane
        fddt_lane u_lane (
            .i_sample (r_s1_samp[k]),
            .o_rgb    (lane_rgb[k])
        );
    end

    fddt_merge u_merge (
        .i_mode   (r_mode),
        .i_native (r_s1_samp[0]),
        .i_lanes  (lane_rgb),
        .o_pixel  (s1_pixel_calc)
    );

    logic r_phase;

    always_comb begin
        s1_visited = 1'b1;
        if (r_mode == fddt_pkg::MODE_INTERLACE && r_s1_row[0] == r_phase) begin
            s1_visited = 1'b0;
        end
        if ((r_mode == fddt_pkg::MODE_CHECKER || r_mode == fddt_pkg::MODE_CHECKER_SINGLE)
            && (r_phase ^ r_s1_row[0] ^ r_s1_col[0])) begin
            s1_visited = 1'b0;
        end
        s1_pixel   = s1_visited ? s1_pixel_calc : 16'd0;
        s1_old     = r_fwd_hit ? r_fwd_data : r_rd_data;
        s1_changed = s1_visited && r_s1_in_frame && (s1_pixel != s1_old);
        wr_en      = s1_fire && s1_changed;
    end

    // dirty rectangle and count
    logic [7:0]  r_min_row;
    logic [7:0]  r_max_row;
    logic [8:0]  r_min_col;
    logic [8:0]  r_max_col;
    logic [16:0] r_count;

    logic [7:0]  n_min_row;
    logic [7:0]  n_max_row;
    logic [8:0]  n_min_col;
    logic [8:0]  n_max_col;
    logic [16:0] n_count;
    logic        box_empty;

    always_comb begin
        box_empty = (r_count == '0);
        n_min_row = r_min_row;
        n_max_row = r_max_row;
        n_min_col = r_min_col;
        n_max_col = r_max_col;
        n_count   = r_count;
        if (s1_changed) begin
            if (r_count != fddt_pkg::COUNT_MAX) begin
                n_count = r_count + 17'd1;
            end
            if (box_empty || r_s1_row < r_min_row) n_min_row = r_s1_row;
            if (box_empty || r_s1_row > r_max_row) n_max_row = r_s1_row;
            if (box_empty || r_s1_col < r_min_col) n_min_col = r_s1_col;
            if (box_empty || r_s1_col > r_max_col) n_max_col = r_s1_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= 1'b1;
            r_count   <= '0;
            r_min_row <= '0;
            r_max_row <= '0;
            r_min_col <= '0;
            r_max_col <= '0;
        end else if (s1_fire) begin
            if (r_s1_last) begin
                r_phase <= ~r_phase;
                r_count <= '0;
            end else begin
                r_count <= n_count;
            end
            r_min_row <= n_min_row;
            r_max_row <= n_max_row;
            r_min_col <= n_min_col;
            r_max_col <= n_max_col;
        end
    end

    // result register
    fddt_pkg::t_result n_result;
    fddt_pkg::t_result r_result;
    logic              n_any;

    always_comb begin
        n_any               = (n_count != '0);
        n_result            = '0;
        n_result.pixel      = s1_pixel;
        n_result.visited    = s1_visited;
        n_result.changed    = s1_changed;
        n_result.out_row    = r_s1_row;
        n_result.out_col    = r_s1_col;
        n_result.frame_done = r_s1_last;
        if (r_s1_last) begin
            n_result.top_row        = n_any ? 16'(n_min_row) : fddt_pkg::BOX_MIN_EMPTY;
            n_result.bottom_row     = n_any ? n_max_row : 8'd0;
            n_result.left_col       = n_any ? 16'(n_min_col) : fddt_pkg::BOX_MIN_EMPTY;
            n_result.right_col      = n_any ? n_max_col : 9'd0;
            n_result.change_count   = n_count;
            n_result.use_dot_writes = n_any && (n_count <= 17'(r_dot_limit));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.pixel          = r_result.pixel;
    assign o_out.visited        = r_result.visited;
    assign o_out.changed        = r_result.changed;
    assign o_out.out_row        = r_result.out_row;
    assign o_out.out_col        = r_result.out_col;
    assign o_out.frame_done     = r_result.frame_done;
    assign o_out.top_row        = r_result.top_row;
    assign o_out.bottom_row     = r_result.bottom_row;
    assign o_out.left_col       = r_result.left_col;
    assign o_out.right_col      = r_result.right_col;
    assign o_out.change_count   = r_result.change_count;
    assign o_out.use_dot_writes = r_result.use_dot_writes;

endmodule

`default_nettype wire

// ===== src/fddt_checker.sv =====
// ----------------------------------------------------------------------------
// fddt_checker
// Port-level checks of the downscaler result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fddt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] i_pixel,
    input wire logic        i_visited,
    input wire logic        i_changed,
    input wire logic        i_frame_done,
    input wire logic [15:0] i_top_row,
    input wire logic [16:0] i_change_count,
    input wire logic        i_use_dot_writes
);

    // nothing comes out in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // skipped positions carry a zero pixel and never change the store
    a_skip_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_visited) |-> (i_pixel == 16'd0 && !i_changed))
        else $error("skipped position with pixel or change");

    // the report is zero outside the frame end
    a_report_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_frame_done) |->
        (i_change_count == 17'd0 && i_top_row == 16'd0 && !i_use_dot_writes))
        else $error("frame report outside frame end");

    // a frame end with a changed pixel reports a nonempty box
    a_report_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_frame_done && i_changed) |->
        (i_change_count != 17'd0 && i_top_row != 16'hFFFF))
        else $error("changed pixel missing from frame report");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_pixel) && $stable(i_change_count)))
        else $error("stalled result dropped or changed");

endmodule

bind frame_downscale_dirty_tracker fddt_checker u_fddt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_pixel          (o_out.pixel),
    .i_visited        (o_out.visited),
    .i_changed        (o_out.changed),
    .i_frame_done     (o_out.frame_done),
    .i_top_row        (o_out.top_row),
    .i_change_count   (o_out.change_count),
    .i_use_dot_writes (o_out.use_dot_writes)
);

`default_nettype wire
